// ===== hdl/pps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int TIME_W = 24;
  localparam int PRIO_W = 8;
  localparam int ID_W   = 5;
  localparam int STAT_W = 3;
  localparam int MODE_W = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_LOADED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_RAN     = 3'd2,
    ST_IDLE    = 3'd3,
    ST_CLEARED = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_FETCH = 5'b00100,
    S_UPD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] response;
  } job_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   job_id;
    logic              completed;
    logic [TIME_W-1:0] time_after_tick;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] response_time;
  } res_t;

endpackage

// ===== hdl/pps_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_in_if / pps_out_if
// Valid/ready channels carrying scheduler commands and results.
// ----------------------------------------------------------------------------
interface pps_in_if;
  logic                        valid;
  logic                        ready;
  logic [pps_pkg::MODE_W-1:0]  mode;
  logic [pps_pkg::TIME_W-1:0]  arrival_time;
  logic [pps_pkg::TIME_W-1:0]  burst_time;
  logic [pps_pkg::PRIO_W-1:0]  prio_level;

  modport source (output valid, mode, arrival_time, burst_time, prio_level, input ready);
  modport sink   (input valid, mode, arrival_time, burst_time, prio_level, output ready);
endinterface

interface pps_out_if;
  logic                        valid;
  logic                        ready;
  logic [pps_pkg::STAT_W-1:0]  status;
  logic [pps_pkg::ID_W-1:0]    job_id;
  logic                        completed;
  logic [pps_pkg::TIME_W-1:0]  time_after_tick;
  logic [pps_pkg::TIME_W-1:0]  completion_time;
  logic [pps_pkg::TIME_W-1:0]  turnaround_time;
  logic [pps_pkg::TIME_W-1:0]  waiting_time;
  logic [pps_pkg::TIME_W-1:0]  response_time;

  modport source (output valid, status, job_id, completed, time_after_tick, completion_time,
                  turnaround_time, waiting_time, response_time, input ready);
  modport sink   (input valid, status, job_id, completed, time_after_tick, completion_time,
                  turnaround_time, waiting_time, response_time, output ready);
endinterface

// ===== hdl/pps_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/preemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Job table with a sequential lowest-priority scan per time tick.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    mode, arrival_time, burst_time, prio_level
//   out_o    out  valid/ready    status, job_id, completed, five time fields
//
// Load and clear register their result, then wait in S_OUT for out_o.ready.
// A tick that runs a job scans the table first: the scan reads one entry per
// cycle through the single RAM read port, then come the fetch, update, output
// and idle states. An idle tick skips fetch and update and goes from the scan
// straight to output.
// in_i.ready is high only while no item is in flight; out_o stalls hold S_OUT.
// Reset clears the job count, time and sequencer; the table needs no clearing.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
  parameter int MAX_JOBS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  pps_in_if.sink    in_i,
  pps_out_if.source out_o
);
  import pps_pkg::*;

  localparam int CW  = $clog2(MAX_JOBS + 1);
  localparam int IW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int IDW = (CW + 1 > ID_W) ? CW + 1 : ID_W;
  localparam int JW  = $bits(job_t);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_JOBS);

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [TIME_W-1:0] clock_q, clock_d;
  logic [CW-1:0]     iss_q, iss_d;
  logic              pend_q, pend_d;
  logic [IW-1:0]     pidx_q, pidx_d;
  logic              found_q, found_d;
  logic [IW-1:0]     best_q, best_d;
  logic [PRIO_W-1:0] bprio_q, bprio_d;
  res_t              res_q, res_d;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  job_t              ram_wdata, ram_rdata;
  logic [JW-1:0]     ram_rbits;

  logic              in_acc, out_acc;
  logic [TIME_W-1:0] clk_next, tat, resp;
  logic [TIME_W-1:0] rem_next;
  logic [IDW-1:0]    load_id, run_id;
  logic              eligible;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign ram_rdata = job_t'(ram_rbits);

  assign clk_next = (clock_q == TIME_MAX) ? clock_q : clock_q + TIME_W'(1);
  assign load_id  = IDW'(count_q) + IDW'(1);
  assign run_id   = IDW'(best_q) + IDW'(1);
  assign rem_next = ram_rdata.remaining - TIME_W'(1);
  assign tat      = clk_next - ram_rdata.arrival;
  assign resp     = (ram_rdata.remaining == ram_rdata.burst) ?
                    clock_q - ram_rdata.arrival : ram_rdata.response;
  assign eligible = (ram_rdata.arrival <= clock_q) && (ram_rdata.remaining != '0);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    clock_d   = clock_q;
    iss_d     = iss_q;
    pend_d    = pend_q;
    pidx_d    = pidx_q;
    found_d   = found_q;
    best_d    = best_q;
    bprio_d   = bprio_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = count_q[IW-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = iss_q[IW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          res_d.time_after_tick = clock_q;
          case (in_i.mode)
            MODE_LOAD: begin
              state_d = S_OUT;
              if (count_q == MaxCount) begin
                res_d.status = ST_FULL;
              end else begin
                ram_we              = 1'b1;
                ram_wdata.arrival   = in_i.arrival_time;
                ram_wdata.burst     = in_i.burst_time;
                ram_wdata.remaining = in_i.burst_time;
                ram_wdata.prio      = in_i.prio_level;
                ram_wdata.response  = '0;
                count_d             = count_q + CW'(1);
                res_d.status        = ST_LOADED;
                res_d.job_id        = load_id[ID_W-1:0];
              end
            end
            MODE_TICK: begin
              state_d = S_SCAN;
              iss_d   = '0;
              pend_d  = 1'b0;
              found_d = 1'b0;
            end
            MODE_CLEAR: begin
              state_d               = S_OUT;
              count_d               = '0;
              clock_d               = '0;
              res_d.status          = ST_CLEARED;
              res_d.time_after_tick = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        ram_re = (iss_q < count_q);
        pend_d = ram_re;
        if (ram_re) begin
          iss_d  = iss_q + CW'(1);
          pidx_d = iss_q[IW-1:0];
        end
        if (pend_q && eligible && (!found_q || ram_rdata.prio < bprio_q)) begin
          found_d = 1'b1;
          best_d  = pidx_q;
          bprio_d = ram_rdata.prio;
        end
        if (!ram_re && !pend_q) begin
          if (found_q) begin
            state_d = S_FETCH;
          end else begin
            state_d               = S_OUT;
            clock_d               = clk_next;
            res_d.status          = ST_IDLE;
            res_d.time_after_tick = clk_next;
          end
        end
      end
      S_FETCH: begin
        ram_re    = 1'b1;
        ram_raddr = best_q;
        state_d   = S_UPD;
      end
      S_UPD: begin
        ram_we              = 1'b1;
        ram_waddr           = best_q;
        ram_wdata.remaining = rem_next;
        ram_wdata.response  = resp;
        clock_d             = clk_next;
        res_d.status          = ST_RAN;
        res_d.job_id          = run_id[ID_W-1:0];
        res_d.time_after_tick = clk_next;
        if (rem_next == '0) begin
          res_d.completed       = 1'b1;
          res_d.completion_time = clk_next;
          res_d.turnaround_time = tat;
          res_d.waiting_time    = (tat >= ram_rdata.burst) ? tat - ram_rdata.burst : '0;
          res_d.response_time   = resp;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      clock_q <= '0;
      iss_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      clock_q <= clock_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q  <= pidx_d;
    best_q  <= best_d;
    bprio_q <= bprio_d;
    res_q   <= res_d;
  end

  pps_ram #(
    .WIDTH (JW),
    .DEPTH (MAX_JOBS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rbits)
  );

  assign in_i.ready            = (state_q == S_IDLE);
  assign out_o.valid           = (state_q == S_OUT);
  assign out_o.status          = res_q.status;
  assign out_o.job_id          = res_q.job_id;
  assign out_o.completed       = res_q.completed;
  assign out_o.time_after_tick = res_q.time_after_tick;
  assign out_o.completion_time = res_q.completion_time;
  assign out_o.turnaround_time = res_q.turnaround_time;
  assign out_o.waiting_time    = res_q.waiting_time;
  assign out_o.response_time   = res_q.response_time;

  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount) else $error("job count above table size");

  a_clock_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clock_q == TIME_MAX) |=> (clock_q == TIME_MAX || clock_q == '0))
    else $error("time counter wrapped");

  a_tick_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.mode == MODE_TICK) |=> (state_q == S_SCAN))
    else $error("tick did not start scan");

  a_scan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (iss_q <= count_q))
    else $error("scan index beyond loaded jobs");

  a_clear_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.mode == MODE_CLEAR) |=> (count_q == '0 && clock_q == '0))
    else $error("clear left state");

endmodule
